@@ rtl/core/bvwt_pkg.sv @@
`default_nettype none
package bvwt_pkg;

   // Store sizes.
   localparam int MAX_VERTS      = 64;
   localparam int MAX_EDGES      = 128;
   localparam int MAX_FACE_VERTS = 32;

   // Field widths fixed by the interface.
   localparam int COORD_W = 40;
   localparam int IDX_W   = 6;
   localparam int LIMIT_W = 32;
   localparam int SUM_W   = 46;

   // Derived widths.
   localparam int VADDR_W = $clog2(MAX_VERTS);
   localparam int VCNT_W  = $clog2(MAX_VERTS + 1);
   localparam int EADDR_W = $clog2(MAX_EDGES);
   localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
   localparam int FADDR_W = $clog2(MAX_FACE_VERTS);
   localparam int FCNT_W  = $clog2(MAX_FACE_VERTS + 1);
   localparam int DIV_W   = SUM_W + 1;
   localparam int DSTEP_W = $clog2(DIV_W);
   localparam int VERT_W  = 3 * COORD_W;
   localparam int EDGE_W  = 2 * IDX_W;

   typedef enum logic [1:0] {
      OP_VERTEX    = 2'd0,
      OP_FACE_END  = 2'd1,
      OP_BRUSH_END = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_VERTEX   = 3'd0,
      KIND_EDGE     = 3'd1,
      KIND_CENTRE   = 3'd2,
      KIND_MIN      = 3'd3,
      KIND_MAX      = 3'd4,
      KIND_OVERFLOW = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // Which result the datapath builds into the output register.
   typedef enum logic [2:0] {
      EM_VERT,
      EM_VOVF,
      EM_EDGE,
      EM_EOVF,
      EM_CENTRE,
      EM_MIN,
      EM_MAX
   } emit_type;

   typedef struct packed {
      logic [1:0]                 opcode;
      logic signed [COORD_W-1:0]  x_coord;
      logic signed [COORD_W-1:0]  y_coord;
      logic signed [COORD_W-1:0]  z_coord;
   } req_type;

   typedef struct packed {
      kind_type                   kind;
      logic [IDX_W-1:0]           index_a;
      logic [IDX_W-1:0]           index_b;
      logic                       is_new;
      logic signed [COORD_W-1:0]  out_x;
      logic signed [COORD_W-1:0]  out_y;
      logic signed [COORD_W-1:0]  out_z;
      logic                       last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                load_req;
      logic [VADDR_W-1:0]  vt_addr;
      logic                vt_we;
      logic                dist_diff;
      logic                mul_en;
      axis_type            mul_axis;
      logic                vert_commit;
      logic [FADDR_W-1:0]  ring_addr;
      logic                pair_cur;
      logic                pair_first;
      logic                pair_wrap;
      logic [EADDR_W-1:0]  edge_addr;
      logic                edge_we;
      logic                div_load;
      logic                div_step;
      logic                div_store;
      axis_type            div_axis;
      logic                face_clear;
      logic                brush_clear;
      logic                emit;
      emit_type            emit_sel;
      logic                emit_last;
      logic [IDX_W-1:0]    emit_idx;
      logic                emit_new;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0]          opcode;
      logic [VCNT_W-1:0]   vt_fill;
      logic [FCNT_W-1:0]   face_len;
      logic [ECNT_W-1:0]   edge_fill;
      logic                near;
      logic                edge_match;
      logic                out_free;
   } status_type;

endpackage
`default_nettype wire

@@ rtl/core/brush_vertex_weld_topology.sv @@
// Brush vertex welding and edge extraction.
// Requests arrive on req_valid/req_ready carrying an opcode and a Q23.16
// vertex; results leave on rsp_valid/rsp_ready, with last set on the final
// result of each request. csr_we/csr_wdata write the squared weld distance limit.
// One request is in work at a time; req_ready is high while the sequencer
// is idle, and a finished result may still wait in the output register.
// A vertex is compared against each stored vertex in turn (one shared
// multiplier, three squares per entry). An end of face searches the edge
// table once per ring vertex, then computes the centre by serial division.
// An end of brush empties every store.
// Reset empties the vertex, face and edge stores at once through their
// fill counts and sets the weld limit to 1; no clearing pass is needed.
// When the receiver stalls, the sequencer holds at its next result until
// the output register is free; nothing is dropped.
`default_nettype none
module brush_vertex_weld_topology (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire bvwt_pkg::req_type            req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output bvwt_pkg::rsp_type                 rsp_data,
   input  wire logic                         csr_we,
   input  wire logic [bvwt_pkg::LIMIT_W-1:0] csr_wdata
);
   import bvwt_pkg::*;

   cmd_type    cmd;
   status_type status;

   bvwt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bvwt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
`default_nettype wire

@@ rtl/core/bvwt_ram.sv @@
`default_nettype none
module bvwt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port, registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ rtl/core/bvwt_datapath.sv @@
`default_nettype none
module bvwt_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire bvwt_pkg::req_type                req_data,
   input  wire logic                             csr_we,
   input  wire logic [bvwt_pkg::LIMIT_W-1:0]     csr_wdata,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_valid,
   output bvwt_pkg::rsp_type                     rsp_data,
   input  wire bvwt_pkg::cmd_type                cmd,
   output bvwt_pkg::status_type                  status
);
   import bvwt_pkg::*;

   req_type                   req_ff;
   logic [LIMIT_W-1:0]        limit_ff;
   logic [VCNT_W-1:0]         vt_fill_ff;
   logic [FCNT_W-1:0]         face_len_ff;
   logic [ECNT_W-1:0]         edge_fill_ff;
   logic signed [COORD_W-1:0] box_low_ff  [3];
   logic signed [COORD_W-1:0] box_high_ff [3];
   logic signed [SUM_W-1:0]   sum_ff      [3];
   logic signed [COORD_W-1:0] centre_ff   [3];
   logic [LIMIT_W-1:0]        adiff_ff    [3];
   logic                      big_ff      [3];
   logic [LIMIT_W:0]          acc_ff;
   logic [IDX_W-1:0]          prev_ff;
   logic [IDX_W-1:0]          first_ff;
   logic [IDX_W-1:0]          pair_lo_ff;
   logic [IDX_W-1:0]          pair_hi_ff;
   logic [DIV_W-1:0]          div_num_ff;
   logic [FCNT_W-1:0]         div_rem_ff;
   logic                      div_neg_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff;

   logic [VERT_W-1:0]         vt_rdata;
   logic [IDX_W-1:0]          ring_rdata;
   logic [EDGE_W-1:0]         edge_rdata;
   logic [FADDR_W-1:0]        ring_addr;
   logic signed [COORD_W-1:0] req_c [3];
   logic signed [COORD_W-1:0] tab_c [3];
   logic signed [COORD_W:0]   diff  [3];
   logic [COORD_W:0]          mag   [3];
   logic [LIMIT_W-1:0]        mul_op;
   logic                      mul_big;
   logic [2*LIMIT_W-1:0]      prod;
   logic [LIMIT_W:0]          acc_sum;
   logic [LIMIT_W:0]          acc_in;
   logic [IDX_W-1:0]          cur_lo;
   logic [IDX_W-1:0]          cur_hi;
   logic [IDX_W-1:0]          wrap_lo;
   logic [IDX_W-1:0]          wrap_hi;
   logic signed [SUM_W-1:0]   div_sum;
   logic [SUM_W-1:0]          div_mag;
   logic [FCNT_W:0]           div_shift;
   logic                      div_ge;
   logic [FCNT_W:0]           div_sub;
   logic [DIV_W-1:0]          div_quot;
   rsp_type                   rsp_in;

   // Stores.
   bvwt_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTS)) u_vert_ram (
      .clock (clock),
      .we    (cmd.vt_we),
      .addr  (cmd.vt_addr),
      .wdata ({req_ff.x_coord, req_ff.y_coord, req_ff.z_coord}),
      .rdata (vt_rdata)
   );

   assign ring_addr = cmd.vert_commit ? face_len_ff[FADDR_W-1:0] : cmd.ring_addr;

   bvwt_ram #(.WIDTH(IDX_W), .DEPTH(MAX_FACE_VERTS)) u_ring_ram (
      .clock (clock),
      .we    (cmd.vert_commit),
      .addr  (ring_addr),
      .wdata (cmd.emit_idx),
      .rdata (ring_rdata)
   );

   bvwt_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock (clock),
      .we    (cmd.edge_we),
      .addr  (cmd.edge_addr),
      .wdata ({pair_lo_ff, pair_hi_ff}),
      .rdata (edge_rdata)
   );

   // Per-axis absolute differences between the request and a stored vertex.
   always_comb begin
      req_c[0] = req_ff.x_coord;
      req_c[1] = req_ff.y_coord;
      req_c[2] = req_ff.z_coord;
      tab_c[0] = vt_rdata[VERT_W-1 -: COORD_W];
      tab_c[1] = vt_rdata[VERT_W-COORD_W-1 -: COORD_W];
      tab_c[2] = vt_rdata[COORD_W-1:0];
      for (int i = 0; i < 3; i++) begin
         diff[i] = $signed({tab_c[i][COORD_W-1], tab_c[i]})
                 - $signed({req_c[i][COORD_W-1], req_c[i]});
         mag[i]  = diff[i][COORD_W] ? (COORD_W+1)'(0) - diff[i] : diff[i];
      end
   end

   // One square per cycle, accumulated with a cap just above any limit.
   always_comb begin
      case (cmd.mul_axis)
         AXIS_X: begin mul_op = adiff_ff[0]; mul_big = big_ff[0]; end
         AXIS_Y: begin mul_op = adiff_ff[1]; mul_big = big_ff[1]; end
         AXIS_Z: begin mul_op = adiff_ff[2]; mul_big = big_ff[2]; end
         default: begin mul_op = '0; mul_big = 1'b1; end
      endcase
      prod    = mul_op * mul_op;
      acc_sum = acc_ff + {1'b0, prod[LIMIT_W-1:0]};
      if (mul_big || (|prod[2*LIMIT_W-1:LIMIT_W]) || acc_ff[LIMIT_W] || acc_sum[LIMIT_W]) begin
         acc_in = {1'b1, {LIMIT_W{1'b0}}};
      end else begin
         acc_in = acc_sum;
      end
   end

   // Edge endpoints in ascending order.
   always_comb begin
      cur_lo  = (prev_ff > ring_rdata) ? ring_rdata : prev_ff;
      cur_hi  = (prev_ff > ring_rdata) ? prev_ff : ring_rdata;
      wrap_lo = (prev_ff > first_ff) ? first_ff : prev_ff;
      wrap_hi = (prev_ff > first_ff) ? prev_ff : first_ff;
   end

   // Restoring divider step and operand selection.
   always_comb begin
      case (cmd.div_axis)
         AXIS_X:  div_sum = sum_ff[0];
         AXIS_Y:  div_sum = sum_ff[1];
         AXIS_Z:  div_sum = sum_ff[2];
         default: div_sum = '0;
      endcase
      div_mag   = div_sum[SUM_W-1] ? SUM_W'(0) - div_sum : div_sum;
      div_shift = {div_rem_ff, div_num_ff[DIV_W-1]};
      div_ge    = div_shift >= {1'b0, face_len_ff};
      div_sub   = div_shift - {1'b0, face_len_ff};
      div_quot  = div_neg_ff ? DIV_W'(0) - div_num_ff : div_num_ff;
   end

   // Result builder.
   always_comb begin
      rsp_in = '0;
      rsp_in.last = cmd.emit_last;
      case (cmd.emit_sel)
         EM_VERT: begin
            rsp_in.kind    = KIND_VERTEX;
            rsp_in.index_a = cmd.emit_idx;
            rsp_in.is_new  = cmd.emit_new;
         end
         EM_VOVF: begin
            rsp_in.kind = KIND_OVERFLOW;
         end
         EM_EDGE: begin
            rsp_in.kind    = KIND_EDGE;
            rsp_in.index_a = pair_lo_ff;
            rsp_in.index_b = pair_hi_ff;
         end
         EM_EOVF: begin
            rsp_in.kind    = KIND_OVERFLOW;
            rsp_in.index_a = pair_lo_ff;
            rsp_in.index_b = pair_hi_ff;
         end
         EM_CENTRE: begin
            rsp_in.kind  = KIND_CENTRE;
            rsp_in.out_x = centre_ff[0];
            rsp_in.out_y = centre_ff[1];
            rsp_in.out_z = centre_ff[2];
         end
         EM_MIN: begin
            rsp_in.kind  = KIND_MIN;
            rsp_in.out_x = box_low_ff[0];
            rsp_in.out_y = box_low_ff[1];
            rsp_in.out_z = box_low_ff[2];
         end
         EM_MAX: begin
            rsp_in.kind  = KIND_MAX;
            rsp_in.out_x = box_high_ff[0];
            rsp_in.out_y = box_high_ff[1];
            rsp_in.out_z = box_high_ff[2];
         end
         default: begin
            rsp_in.kind = KIND_OVERFLOW;
         end
      endcase
   end

   // Fill counts, bounding box, face sums, limit and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_W'(1);
         vt_fill_ff   <= '0;
         face_len_ff  <= '0;
         edge_fill_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            box_low_ff[i]  <= '0;
            box_high_ff[i] <= '0;
            sum_ff[i]      <= '0;
         end
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         if (cmd.vt_we) begin
            vt_fill_ff <= vt_fill_ff + 1'b1;
            for (int i = 0; i < 3; i++) begin
               if (vt_fill_ff == '0 || req_c[i] < box_low_ff[i]) begin
                  box_low_ff[i] <= req_c[i];
               end
               if (vt_fill_ff == '0 || req_c[i] > box_high_ff[i]) begin
                  box_high_ff[i] <= req_c[i];
               end
            end
         end
         if (cmd.vert_commit) begin
            face_len_ff <= face_len_ff + 1'b1;
            for (int i = 0; i < 3; i++) begin
               sum_ff[i] <= sum_ff[i]
                          + $signed({{(SUM_W-COORD_W){req_c[i][COORD_W-1]}}, req_c[i]});
            end
         end
         if (cmd.edge_we) begin
            edge_fill_ff <= edge_fill_ff + 1'b1;
         end
         if (cmd.face_clear || cmd.brush_clear) begin
            face_len_ff <= '0;
            for (int i = 0; i < 3; i++) begin
               sum_ff[i] <= '0;
            end
         end
         if (cmd.brush_clear) begin
            vt_fill_ff   <= '0;
            edge_fill_ff <= '0;
            for (int i = 0; i < 3; i++) begin
               box_low_ff[i]  <= '0;
               box_high_ff[i] <= '0;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request register, working registers of the search, edge walk and divider, and output data.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.dist_diff) begin
         acc_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            adiff_ff[i] <= mag[i][LIMIT_W-1:0];
            big_ff[i]   <= |mag[i][COORD_W:LIMIT_W];
         end
      end
      if (cmd.mul_en) begin
         acc_ff <= acc_in;
      end
      if (cmd.pair_cur) begin
         prev_ff    <= ring_rdata;
         pair_lo_ff <= cur_lo;
         pair_hi_ff <= cur_hi;
         if (cmd.pair_first) begin
            first_ff <= ring_rdata;
         end
      end
      if (cmd.pair_wrap) begin
         pair_lo_ff <= wrap_lo;
         pair_hi_ff <= wrap_hi;
      end
      if (cmd.div_load) begin
         div_neg_ff <= div_sum[SUM_W-1];
         div_rem_ff <= '0;
         div_num_ff <= {1'b0, div_mag} + DIV_W'(face_len_ff >> 1);
      end
      if (cmd.div_step) begin
         div_rem_ff <= div_ge ? div_sub[FCNT_W-1:0] : div_shift[FCNT_W-1:0];
         div_num_ff <= {div_num_ff[DIV_W-2:0], div_ge};
      end
      if (cmd.div_store) begin
         for (int i = 0; i < 3; i++) begin
            if (cmd.div_axis == axis_type'(i)) begin
               centre_ff[i] <= (face_len_ff == '0) ? '0 : div_quot[COORD_W-1:0];
            end
         end
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      status.opcode     = req_ff.opcode;
      status.vt_fill    = vt_fill_ff;
      status.face_len   = face_len_ff;
      status.edge_fill  = edge_fill_ff;
      status.near       = acc_ff < {1'b0, limit_ff};
      status.edge_match = edge_rdata == {pair_lo_ff, pair_hi_ff};
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule
`default_nettype wire

@@ rtl/core/bvwt_ctrl.sv @@
`default_nettype none
module bvwt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire bvwt_pkg::status_type status,
   output bvwt_pkg::cmd_type         cmd
);
   import bvwt_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE,
      S_VCHECK, S_VRD, S_VDIF, S_VMUL, S_VCMP, S_VNEW, S_VCOMMIT, S_VEMIT, S_VOVF,
      S_FISSUE, S_FDATA, S_FWRAP,
      S_ECHECK, S_ERD, S_ECMP, S_ENEW, S_ENEXT,
      S_DLOAD, S_DSTEP, S_DSTORE, S_CEMIT,
      S_BMIN, S_BMAX
   } state_type;

   state_type          state_ff;
   logic [VCNT_W-1:0]  scan_ff;
   logic               fresh_ff;
   logic [FCNT_W-1:0]  vpos_ff;
   logic [ECNT_W-1:0]  escan_ff;
   logic               wrap_ff;
   axis_type           axis_ff;
   logic [DSTEP_W-1:0] dstep_ff;

   axis_type           axis_next;
   logic               vt_full;
   logic               edge_full;

   always_comb begin
      case (axis_ff)
         AXIS_X:  axis_next = AXIS_Y;
         AXIS_Y:  axis_next = AXIS_Z;
         default: axis_next = AXIS_X;
      endcase
      vt_full   = status.vt_fill >= VCNT_W'(MAX_VERTS);
      edge_full = status.edge_fill >= ECNT_W'(MAX_EDGES);
   end

   assign req_ready = (state_ff == S_IDLE);

   // Commands decoded from the current state.
   always_comb begin
      cmd           = '0;
      cmd.vt_addr   = scan_ff[VADDR_W-1:0];
      cmd.ring_addr = vpos_ff[FADDR_W-1:0];
      cmd.edge_addr = escan_ff[EADDR_W-1:0];
      cmd.emit_idx  = IDX_W'(scan_ff);
      cmd.emit_new  = fresh_ff;
      cmd.mul_axis  = axis_ff;
      cmd.div_axis  = axis_ff;
      cmd.emit_sel  = EM_VERT;
      case (state_ff)
         S_IDLE:    cmd.load_req = req_valid;
         S_VDIF:    cmd.dist_diff = 1'b1;
         S_VMUL:    cmd.mul_en = 1'b1;
         S_VNEW:    cmd.vt_we = !vt_full;
         S_VCOMMIT: cmd.vert_commit = 1'b1;
         S_VEMIT: begin
            cmd.emit      = status.out_free;
            cmd.emit_last = 1'b1;
         end
         S_VOVF: begin
            cmd.emit      = status.out_free;
            cmd.emit_sel  = EM_VOVF;
            cmd.emit_last = 1'b1;
         end
         S_FDATA: begin
            cmd.pair_cur   = 1'b1;
            cmd.pair_first = (vpos_ff == '0);
         end
         S_FWRAP:   cmd.pair_wrap = 1'b1;
         S_ENEW: begin
            cmd.emit     = status.out_free;
            cmd.emit_sel = edge_full ? EM_EOVF : EM_EDGE;
            cmd.edge_we  = status.out_free && !edge_full;
         end
         S_DLOAD:   cmd.div_load = 1'b1;
         S_DSTEP:   cmd.div_step = 1'b1;
         S_DSTORE:  cmd.div_store = 1'b1;
         S_CEMIT: begin
            cmd.emit       = status.out_free;
            cmd.emit_sel   = EM_CENTRE;
            cmd.emit_last  = 1'b1;
            cmd.face_clear = status.out_free;
         end
         S_BMIN: begin
            cmd.emit     = status.out_free;
            cmd.emit_sel = EM_MIN;
         end
         S_BMAX: begin
            cmd.emit        = status.out_free;
            cmd.emit_sel    = EM_MAX;
            cmd.emit_last   = 1'b1;
            cmd.brush_clear = status.out_free;
         end
         default: cmd.load_req = 1'b0;
      endcase
   end

   // Sequencer state and loop counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         scan_ff  <= '0;
         fresh_ff <= 1'b0;
         vpos_ff  <= '0;
         escan_ff <= '0;
         wrap_ff  <= 1'b0;
         axis_ff  <= AXIS_X;
         dstep_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               scan_ff <= '0;
               vpos_ff <= '0;
               axis_ff <= AXIS_X;
               case (status.opcode)
                  OP_VERTEX: begin
                     if (status.face_len >= FCNT_W'(MAX_FACE_VERTS)) begin
                        state_ff <= S_VOVF;
                     end else begin
                        state_ff <= S_VCHECK;
                     end
                  end
                  OP_FACE_END: begin
                     state_ff <= (status.face_len == '0) ? S_DLOAD : S_FISSUE;
                  end
                  OP_BRUSH_END: state_ff <= S_BMIN;
                  default:      state_ff <= S_IDLE;
               endcase
            end
            // Weld search over the stored vertices.
            S_VCHECK: state_ff <= (scan_ff == status.vt_fill) ? S_VNEW : S_VRD;
            S_VRD:    state_ff <= S_VDIF;
            S_VDIF: begin
               axis_ff  <= AXIS_X;
               state_ff <= S_VMUL;
            end
            S_VMUL: begin
               axis_ff <= axis_next;
               if (axis_ff == AXIS_Z) begin
                  state_ff <= S_VCMP;
               end
            end
            S_VCMP: begin
               if (status.near) begin
                  fresh_ff <= 1'b0;
                  state_ff <= S_VCOMMIT;
               end else begin
                  scan_ff  <= scan_ff + 1'b1;
                  state_ff <= S_VCHECK;
               end
            end
            S_VNEW: begin
               if (vt_full) begin
                  state_ff <= S_VOVF;
               end else begin
                  fresh_ff <= 1'b1;
                  state_ff <= S_VCOMMIT;
               end
            end
            S_VCOMMIT: state_ff <= S_VEMIT;
            S_VEMIT, S_VOVF: begin
               if (status.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            // Walk the face ring in order, pairing neighbors.
            S_FISSUE: state_ff <= S_FDATA;
            S_FDATA: begin
               if (vpos_ff == '0) begin
                  if (status.face_len == FCNT_W'(1)) begin
                     state_ff <= S_FWRAP;
                  end else begin
                     vpos_ff  <= vpos_ff + 1'b1;
                     state_ff <= S_FISSUE;
                  end
               end else begin
                  wrap_ff  <= 1'b0;
                  escan_ff <= '0;
                  state_ff <= S_ECHECK;
               end
            end
            S_FWRAP: begin
               wrap_ff  <= 1'b1;
               escan_ff <= '0;
               state_ff <= S_ECHECK;
            end
            // Look the edge up in the edge table.
            S_ECHECK: state_ff <= (escan_ff == status.edge_fill) ? S_ENEW : S_ERD;
            S_ERD:    state_ff <= S_ECMP;
            S_ECMP: begin
               if (status.edge_match) begin
                  state_ff <= S_ENEXT;
               end else begin
                  escan_ff <= escan_ff + 1'b1;
                  state_ff <= S_ECHECK;
               end
            end
            S_ENEW: begin
               if (status.out_free) begin
                  state_ff <= S_ENEXT;
               end
            end
            S_ENEXT: begin
               if (wrap_ff) begin
                  axis_ff  <= AXIS_X;
                  state_ff <= S_DLOAD;
               end else if (FCNT_W'(vpos_ff + 1'b1) == status.face_len) begin
                  state_ff <= S_FWRAP;
               end else begin
                  vpos_ff  <= vpos_ff + 1'b1;
                  state_ff <= S_FISSUE;
               end
            end
            // Face centre, one axis at a time.
            S_DLOAD: begin
               dstep_ff <= '0;
               state_ff <= S_DSTEP;
            end
            S_DSTEP: begin
               dstep_ff <= dstep_ff + 1'b1;
               if (dstep_ff == DSTEP_W'(DIV_W - 1)) begin
                  state_ff <= S_DSTORE;
               end
            end
            S_DSTORE: begin
               axis_ff <= axis_next;
               state_ff <= (axis_ff == AXIS_Z) ? S_CEMIT : S_DLOAD;
            end
            S_CEMIT: begin
               if (status.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            S_BMIN: begin
               if (status.out_free) begin
                  state_ff <= S_BMAX;
               end
            end
            S_BMAX: begin
               if (status.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire
